FILE: design/awg_pkg.sv
// ----------------------------------------------------------------------------
// awg_pkg: shared types and constants for the airtime window governor
// Operation codes, register indexes, sequencer states and divider request.
// ----------------------------------------------------------------------------
`default_nettype none

package awg_pkg;

    localparam int BUCKET_DEPTH_DEF   = 256;
    localparam int BEACON_DEPTH_DEF   = 32;
    localparam int BUCKET_SPAN_MS_DEF = 100;

    // divider: numerator wide enough for window*10, denominator for 16-bit rates
    localparam int DIV_W = 36;
    localparam int DEN_W = 16;

    localparam logic [1:0] OP_ROUTINE = 2'd0;
    localparam logic [1:0] OP_URGENT  = 2'd1;
    localparam logic [1:0] OP_BEACON  = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [3:0] REG_CAP_PERCENT = 4'd0;
    localparam logic [3:0] REG_WINDOW_MS   = 4'd1;
    localparam logic [3:0] REG_PHY_RATE    = 4'd2;
    localparam logic [3:0] REG_PREAMBLE    = 4'd3;

    localparam logic [6:0]  CAP_RESET      = 7'd2;
    localparam logic [14:0] WINDOW_RESET   = 15'd10000;
    localparam logic [15:0] RATE_RESET     = 16'd250;
    localparam logic [15:0] PREAMBLE_RESET = 16'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COST_GO,
        ST_COST_WAIT,
        ST_SPAN_GO,
        ST_SPAN_WAIT,
        ST_SPAN_FIX,
        ST_DECIDE,
        ST_CAP,
        ST_WALK,
        ST_NEED,
        ST_COMMIT,
        ST_BWALK,
        ST_PCT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

`default_nettype wire

FILE: design/airtime_window_governor.sv
// Sequence: the airtime divide, a walk over every filled bucket, then the usage
// divide, which runs alongside the beacon walk, and the sequencing states.
// Throughput: one request at a time; in_ready is high only while the sequencer
// idles. Reset: configuration and control registers take their reset values;
// rings start empty (fill counts zero), so no clearing pass is needed.
// ----------------------------------------------------------------------------
// airtime_window_governor: sliding-window airtime limiter
// Buckets airtime sends over time, grants routine sends under a cap and reports
// window usage, counters and beacon airtime for every request.
// ----------------------------------------------------------------------------
`default_nettype none

module airtime_window_governor #(
    parameter int BUCKET_DEPTH   = awg_pkg::BUCKET_DEPTH_DEF,
    parameter int BEACON_DEPTH   = awg_pkg::BEACON_DEPTH_DEF,
    parameter int BUCKET_SPAN_MS = awg_pkg::BUCKET_SPAN_MS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] now_ms,
    input  wire logic [11:0] frame_bytes,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             granted,
    output logic [31:0]      window_airtime,
    output logic [15:0]      usage_pct_x100,
    output logic [31:0]      routine_granted_count,
    output logic [31:0]      routine_refused_count,
    output logic [31:0]      urgent_count,
    output logic [31:0]      beacon_count,
    output logic [31:0]      beacon_airtime
);

    localparam int BAW = $clog2(BUCKET_DEPTH);
    localparam int BFW = $clog2(BUCKET_DEPTH + 1);
    localparam int EAW = $clog2(BEACON_DEPTH);
    localparam int EFW = $clog2(BEACON_DEPTH + 1);
    localparam int WCW = (BFW > EFW) ? BFW : EFW;
    // floor(2^32 / span): the estimate now*recip >> 32 is low by at most one
    localparam logic [32:0] SPAN_RECIP = 33'((64'd1 << 32) / BUCKET_SPAN_MS);

    // configuration
    logic [6:0]  cap_reg;
    logic [14:0] wl_reg;
    logic [15:0] rate_reg;
    logic [15:0] pre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= awg_pkg::CAP_RESET;
            wl_reg   <= awg_pkg::WINDOW_RESET;
            rate_reg <= awg_pkg::RATE_RESET;
            pre_reg  <= awg_pkg::PREAMBLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                awg_pkg::REG_CAP_PERCENT: cap_reg  <= cfg_data[6:0];
                awg_pkg::REG_WINDOW_MS:   wl_reg   <= cfg_data[14:0];
                awg_pkg::REG_PHY_RATE:    rate_reg <= cfg_data;
                awg_pkg::REG_PREAMBLE:    pre_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    awg_pkg::state_t state_reg, state_next;

    logic [1:0]  op_reg, op_next;
    logic [31:0] now_reg, now_next;
    logic [11:0] bytes_reg, bytes_next;
    logic [31:0] cost_reg, cost_next;
    logic [31:0] qbase_reg, qbase_next;
    logic [31:0] lst_stamp_reg, lst_stamp_next;
    logic [31:0] lst_air_reg, lst_air_next;
    logic        merge_reg, merge_next;
    logic [BAW-1:0] tgt_reg, tgt_next;
    logic [31:0] nstamp_reg, nstamp_next;
    logic [31:0] nair_reg, nair_next;
    logic [24:0] capa_reg, capa_next;
    logic [32:0] capx_reg, capx_next;
    logic [39:0] need_reg, need_next;
    logic [31:0] pre_sum_reg, pre_sum_next;
    logic [31:0] post_sum_reg, post_sum_next;
    logic [31:0] bsum_reg, bsum_next;
    logic [31:0] win_reg, win_next;
    logic [15:0] pct_reg, pct_next;
    logic        grant_reg, grant_next;
    logic [WCW-1:0] idx_reg, idx_next;
    logic [WCW-1:0] ridx_reg, ridx_next;
    logic        pend_reg, pend_next;

    logic [BAW-1:0] bhead_reg, bhead_next;
    logic [BFW-1:0] bfill_reg, bfill_next;
    logic [EAW-1:0] ehead_reg, ehead_next;
    logic [EFW-1:0] efill_reg, efill_next;
    logic [31:0] t_ok_reg, t_ok_next;
    logic [31:0] t_no_reg, t_no_next;
    logic [31:0] t_urg_reg, t_urg_next;
    logic [31:0] t_bcn_reg, t_bcn_next;

    logic        ov_reg, ov_next;
    logic        o_grant_reg, o_grant_next;
    logic [31:0] o_win_reg, o_win_next;
    logic [15:0] o_pct_reg, o_pct_next;
    logic [31:0] o_ok_reg, o_ok_next;
    logic [31:0] o_no_reg, o_no_next;
    logic [31:0] o_urg_reg, o_urg_next;
    logic [31:0] o_bcn_reg, o_bcn_next;
    logic [31:0] o_bsum_reg, o_bsum_next;

    // ring and divider hookup
    logic           b_wr_en, b_rd_en, e_wr_en, e_rd_en;
    logic [BAW-1:0] b_rd_addr;
    logic [63:0]    b_wr_data, b_rd_data, e_wr_data, e_rd_data;
    awg_pkg::div_req_t         div_req;
    logic                      div_busy;
    logic [awg_pkg::DIV_W-1:0] div_quo;

    // walk datapath
    logic [31:0] w_stamp, w_amount, c_old, c_new;
    logic [BAW-1:0] last_idx;
    logic [32:0] bdiff;
    logic [31:0] sdiff;
    logic [64:0] span_prod;
    logic [15:0] rate1;
    logic [6:0]  pctcap;
    logic        accept_in, out_free, walk_more, fire;

    awg_ring #(.DEPTH(BUCKET_DEPTH), .WIDTH(64)) u_bucket (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (tgt_reg),
        .wr_data (b_wr_data),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    awg_ring #(.DEPTH(BEACON_DEPTH), .WIDTH(64)) u_beacon (
        .clk     (clk),
        .wr_en   (e_wr_en),
        .wr_addr (ehead_reg),
        .wr_data (e_wr_data),
        .rd_en   (e_rd_en),
        .rd_addr (idx_reg[EAW-1:0]),
        .rd_data (e_rd_data)
    );

    awg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign in_ready  = state_reg == awg_pkg::ST_IDLE;
    assign accept_in = in_valid && in_ready;
    assign out_free  = !ov_reg || out_ready;
    assign rate1     = (rate_reg == 16'd0) ? 16'd1 : rate_reg;
    assign pctcap    = (cap_reg == 7'd0) ? awg_pkg::CAP_RESET : cap_reg;
    assign last_idx  = (bhead_reg == '0) ? BAW'(BUCKET_DEPTH - 1) : bhead_reg - BAW'(1);
    assign bdiff     = {1'b0, lst_stamp_reg} - {1'b0, qbase_reg};
    assign sdiff     = now_reg - lst_stamp_reg;
    assign span_prod = {33'd0, now_reg} * {32'd0, SPAN_RECIP};

    always_comb
    begin
        w_stamp  = (state_reg == awg_pkg::ST_BWALK) ? e_rd_data[63:32] : b_rd_data[63:32];
        w_amount = (state_reg == awg_pkg::ST_BWALK) ? e_rd_data[31:0]  : b_rd_data[31:0];
        c_old    = ((now_reg - w_stamp) <= {17'd0, wl_reg}) ? w_amount : 32'd0;
        c_new    = ((now_reg - nstamp_reg) <= {17'd0, wl_reg}) ? nair_reg : 32'd0;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        bytes_next     = bytes_reg;
        cost_next      = cost_reg;
        qbase_next     = qbase_reg;
        lst_stamp_next = lst_stamp_reg;
        lst_air_next   = lst_air_reg;
        merge_next     = merge_reg;
        tgt_next       = tgt_reg;
        nstamp_next    = nstamp_reg;
        nair_next      = nair_reg;
        capa_next      = capa_reg;
        capx_next      = capx_reg;
        need_next      = need_reg;
        pre_sum_next   = pre_sum_reg;
        post_sum_next  = post_sum_reg;
        bsum_next      = bsum_reg;
        win_next       = win_reg;
        pct_next       = pct_reg;
        grant_next     = grant_reg;
        idx_next       = idx_reg;
        ridx_next      = ridx_reg;
        pend_next      = 1'b0;
        bhead_next     = bhead_reg;
        bfill_next     = bfill_reg;
        ehead_next     = ehead_reg;
        efill_next     = efill_reg;
        t_ok_next      = t_ok_reg;
        t_no_next      = t_no_reg;
        t_urg_next     = t_urg_reg;
        t_bcn_next     = t_bcn_reg;
        ov_next        = ov_reg && !out_ready;
        o_grant_next   = o_grant_reg;
        o_win_next     = o_win_reg;
        o_pct_next     = o_pct_reg;
        o_ok_next      = o_ok_reg;
        o_no_next      = o_no_reg;
        o_urg_next     = o_urg_reg;
        o_bcn_next     = o_bcn_reg;
        o_bsum_next    = o_bsum_reg;
        b_wr_en        = 1'b0;
        b_rd_en        = 1'b0;
        b_rd_addr      = idx_reg[BAW-1:0];
        b_wr_data      = {nstamp_reg, nair_reg};
        e_wr_en        = 1'b0;
        e_rd_en        = 1'b0;
        e_wr_data      = {now_reg, cost_reg};
        div_req        = '0;
        walk_more      = 1'b0;
        fire           = 1'b0;

        unique case (state_reg)
            awg_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    op_next    = operation;
                    now_next   = now_ms;
                    bytes_next = frame_bytes;
                    state_next = awg_pkg::ST_COST_GO;
                end
            end
            awg_pkg::ST_COST_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = {24'd0, bytes_reg} * 36'd8000;
                div_req.den   = rate1;
                b_rd_en       = 1'b1;
                b_rd_addr     = last_idx;
                state_next    = awg_pkg::ST_COST_WAIT;
            end
            awg_pkg::ST_COST_WAIT:
            begin
                lst_stamp_next = b_rd_data[63:32];
                lst_air_next   = b_rd_data[31:0];
                if (!div_busy)
                begin
                    cost_next  = {16'd0, pre_reg} + div_quo[31:0];
                    state_next = awg_pkg::ST_SPAN_GO;
                end
            end
            awg_pkg::ST_SPAN_GO:
            begin
                // quotient estimate of now / span
                qbase_next = span_prod[63:32];
                state_next = awg_pkg::ST_SPAN_WAIT;
            end
            awg_pkg::ST_SPAN_WAIT:
            begin
                qbase_next = qbase_reg * 32'(BUCKET_SPAN_MS);
                state_next = awg_pkg::ST_SPAN_FIX;
            end
            awg_pkg::ST_SPAN_FIX:
            begin
                // advance one span when the estimate came out low
                qbase_next = ((now_reg - qbase_reg) >= 32'(BUCKET_SPAN_MS))
                             ? qbase_reg + 32'(BUCKET_SPAN_MS) : qbase_reg;
                state_next = awg_pkg::ST_DECIDE;
            end
            awg_pkg::ST_DECIDE:
            begin
                // same bucket period as the newest bucket: fold into it
                merge_next = (bfill_reg != '0) && !bdiff[32]
                             && (bdiff[31:0] < 32'(BUCKET_SPAN_MS));
                if (merge_next)
                begin
                    tgt_next    = last_idx;
                    nstamp_next = (sdiff != 32'd0 && !sdiff[31]) ? now_reg : lst_stamp_reg;
                    nair_next   = lst_air_reg + cost_reg;
                end
                else
                begin
                    tgt_next    = bhead_reg;
                    nstamp_next = now_reg;
                    nair_next   = cost_reg;
                end
                capa_next  = {10'd0, wl_reg} * 25'd1000;
                state_next = awg_pkg::ST_CAP;
            end
            awg_pkg::ST_CAP:
            begin
                capx_next    = {8'd0, capa_reg} * {26'd0, pctcap};
                idx_next     = '0;
                pre_sum_next = 32'd0;
                post_sum_next = (!merge_reg && bfill_reg != BFW'(BUCKET_DEPTH))
                                ? cost_reg : 32'd0;
                state_next   = awg_pkg::ST_WALK;
            end
            awg_pkg::ST_WALK:
            begin
                walk_more = idx_reg < WCW'(bfill_reg);
                if (walk_more)
                begin
                    b_rd_en   = 1'b1;
                    pend_next = 1'b1;
                    ridx_next = idx_reg;
                    idx_next  = idx_reg + WCW'(1);
                end
                if (pend_reg)
                begin
                    pre_sum_next = pre_sum_reg + c_old;
                    post_sum_next = post_sum_reg
                                    + ((ridx_reg[BAW-1:0] == tgt_reg) ? c_new : c_old);
                end
                if (!walk_more && !pend_reg)
                begin
                    state_next = awg_pkg::ST_NEED;
                end
            end
            awg_pkg::ST_NEED:
            begin
                need_next  = ({7'd0, pre_sum_reg} + {7'd0, cost_reg}) * 40'd100;
                state_next = awg_pkg::ST_COMMIT;
            end
            awg_pkg::ST_COMMIT:
            begin
                case (op_reg)
                    awg_pkg::OP_ROUTINE: fire = need_reg <= {7'd0, capx_reg};
                    awg_pkg::OP_QUERY:   fire = 1'b0;
                    default:             fire = 1'b1;
                endcase
                grant_next = fire;
                win_next   = fire ? post_sum_reg : pre_sum_reg;
                if (fire)
                begin
                    b_wr_en = 1'b1;
                    if (!merge_reg)
                    begin
                        bhead_next = (bhead_reg == BAW'(BUCKET_DEPTH - 1))
                                     ? '0 : bhead_reg + BAW'(1);
                        if (bfill_reg != BFW'(BUCKET_DEPTH))
                        begin
                            bfill_next = bfill_reg + BFW'(1);
                        end
                    end
                end
                case (op_reg)
                    awg_pkg::OP_ROUTINE:
                    begin
                        if (fire)
                        begin
                            t_ok_next = t_ok_reg + 32'd1;
                        end
                        else
                        begin
                            t_no_next = t_no_reg + 32'd1;
                        end
                    end
                    awg_pkg::OP_URGENT: t_urg_next = t_urg_reg + 32'd1;
                    awg_pkg::OP_BEACON:
                    begin
                        e_wr_en    = 1'b1;
                        ehead_next = (ehead_reg == EAW'(BEACON_DEPTH - 1))
                                     ? '0 : ehead_reg + EAW'(1);
                        if (efill_reg != EFW'(BEACON_DEPTH))
                        begin
                            efill_next = efill_reg + EFW'(1);
                        end
                        t_bcn_next = t_bcn_reg + 32'd1;
                    end
                    default: ;
                endcase
                // usage = win*10000/(window*1000) = win*10/window
                if (wl_reg != 15'd0)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {4'd0, win_next} * 36'd10;
                    div_req.den   = {1'b0, wl_reg};
                end
                idx_next   = '0;
                bsum_next  = 32'd0;
                state_next = awg_pkg::ST_BWALK;
            end
            awg_pkg::ST_BWALK:
            begin
                walk_more = idx_reg < WCW'(efill_reg);
                if (walk_more)
                begin
                    e_rd_en   = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + WCW'(1);
                end
                if (pend_reg)
                begin
                    bsum_next = bsum_reg + c_old;
                end
                if (!walk_more && !pend_reg)
                begin
                    state_next = awg_pkg::ST_PCT;
                end
            end
            awg_pkg::ST_PCT:
            begin
                if (wl_reg == 15'd0)
                begin
                    pct_next   = 16'd0;
                    state_next = awg_pkg::ST_OUT;
                end
                else if (!div_busy)
                begin
                    pct_next   = (div_quo > awg_pkg::DIV_W'(16'hFFFF))
                                 ? 16'hFFFF : div_quo[15:0];
                    state_next = awg_pkg::ST_OUT;
                end
            end
            awg_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_grant_next = grant_reg;
                    o_win_next   = win_reg;
                    o_pct_next   = pct_reg;
                    o_ok_next    = t_ok_reg;
                    o_no_next    = t_no_reg;
                    o_urg_next   = t_urg_reg;
                    o_bcn_next   = t_bcn_reg;
                    o_bsum_next  = bsum_reg;
                    state_next   = awg_pkg::ST_IDLE;
                end
            end
            default: state_next = awg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= awg_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
            bhead_reg <= '0;
            bfill_reg <= '0;
            ehead_reg <= '0;
            efill_reg <= '0;
            t_ok_reg  <= '0;
            t_no_reg  <= '0;
            t_urg_reg <= '0;
            t_bcn_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            bhead_reg <= bhead_next;
            bfill_reg <= bfill_next;
            ehead_reg <= ehead_next;
            efill_reg <= efill_next;
            t_ok_reg  <= t_ok_next;
            t_no_reg  <= t_no_next;
            t_urg_reg <= t_urg_next;
            t_bcn_reg <= t_bcn_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        bytes_reg     <= bytes_next;
        cost_reg      <= cost_next;
        qbase_reg     <= qbase_next;
        lst_stamp_reg <= lst_stamp_next;
        lst_air_reg   <= lst_air_next;
        merge_reg     <= merge_next;
        tgt_reg       <= tgt_next;
        nstamp_reg    <= nstamp_next;
        nair_reg      <= nair_next;
        capa_reg      <= capa_next;
        capx_reg      <= capx_next;
        need_reg      <= need_next;
        pre_sum_reg   <= pre_sum_next;
        post_sum_reg  <= post_sum_next;
        bsum_reg      <= bsum_next;
        win_reg       <= win_next;
        pct_reg       <= pct_next;
        grant_reg     <= grant_next;
        idx_reg       <= idx_next;
        ridx_reg      <= ridx_next;
        o_grant_reg   <= o_grant_next;
        o_win_reg     <= o_win_next;
        o_pct_reg     <= o_pct_next;
        o_ok_reg      <= o_ok_next;
        o_no_reg      <= o_no_next;
        o_urg_reg     <= o_urg_next;
        o_bcn_reg     <= o_bcn_next;
        o_bsum_reg    <= o_bsum_next;
    end

    assign out_valid             = ov_reg;
    assign granted               = o_grant_reg;
    assign window_airtime        = o_win_reg;
    assign usage_pct_x100        = o_pct_reg;
    assign routine_granted_count = o_ok_reg;
    assign routine_refused_count = o_no_reg;
    assign urgent_count          = o_urg_reg;
    assign beacon_count          = o_bcn_reg;
    assign beacon_airtime        = o_bsum_reg;

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == awg_pkg::ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (bfill_reg <= BFW'(BUCKET_DEPTH)) && (efill_reg <= EFW'(BEACON_DEPTH)))
        else $error("ring fill out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> !in_ready)
        else $error("request taken while sequencer busy");

    a_grant_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == awg_pkg::ST_COMMIT && op_reg == awg_pkg::OP_QUERY) |=> !grant_reg)
        else $error("query granted");

endmodule

`default_nettype wire

FILE: design/awg_ring.sv
// ----------------------------------------------------------------------------
// awg_ring: single-port-write, single-port-read ring storage
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module awg_ring #(
    parameter int DEPTH = awg_pkg::BUCKET_DEPTH_DEF,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/awg_div.sv
// ----------------------------------------------------------------------------
// awg_div: shared restoring divider
// One quotient bit per cycle; quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module awg_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire awg_pkg::div_req_t        req,
    output logic                          busy,
    output logic [awg_pkg::DIV_W-1:0]     quo
);

    localparam int CW = $clog2(awg_pkg::DIV_W + 1);

    logic [awg_pkg::DIV_W-1:0] num_reg, num_next;
    logic [awg_pkg::DEN_W-1:0] den_reg, den_next;
    logic [awg_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [awg_pkg::DEN_W:0]   trial;
    logic                      fits;

    always_comb
    begin
        trial    = {rem_reg, num_reg[awg_pkg::DIV_W-1]};
        fits     = trial >= {1'b0, den_reg};
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = CW'(awg_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit, quotient bit enters at the bottom
            rem_next = fits ? awg_pkg::DEN_W'(trial - {1'b0, den_reg})
                            : trial[awg_pkg::DEN_W-1:0];
            num_next = {num_reg[awg_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            busy_next = cnt_reg != CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign quo  = num_reg;

endmodule

`default_nettype wire
